// File: hw/rtl/zpc_pkg.sv
// zpc_pkg: shared types and constants of the zero-padded 2-D convolution unit.
// Field widths, request function codes, register indexes and stage tags.
// No dependencies.
package zpc_pkg;

	localparam int PIX_W      = 8;
	localparam int COEF_W     = 18;
	localparam int IDX_W      = 5;
	localparam int FUNC_W     = 2;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 10;
	localparam int WREG_W     = 11;
	localparam int HREG_W     = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam int MAX_HEIGHT = 4096;
	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;

	// coefficients are Q1.16
	localparam int FRAC_BITS  = 16;
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DRAIN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 1'd1;

	// position of an output pixel as it travels down the datapath
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} tag_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             clamped;
		logic             frame_last;
	} result_t;

endpackage

// File: hw/rtl/zpc_if.sv
// zpc_if: valid/ready channels of the convolution unit (request in, result out).
// Depends on zpc_pkg.
interface zpc_item_if;
	import zpc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [PIX_W-1:0]         pixel;
	logic [IDX_W-1:0]         coef_index;
	logic signed [COEF_W-1:0] coef_value;

	modport source (output valid, func, pixel, coef_index, coef_value, input ready);
	modport sink (input valid, func, pixel, coef_index, coef_value, output ready);
endinterface

interface zpc_result_if;
	import zpc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic             clamped;
	logic             frame_last;

	modport source (output valid, out_pixel, out_row, out_col, clamped, frame_last, input ready);
	modport sink (input valid, out_pixel, out_row, out_col, clamped, frame_last, output ready);
endinterface

// File: hw/rtl/zpc_line_buf.sv
// zpc_line_buf: line memory, one write and one registered read per cycle.
// A read of the address being written in the same cycle returns the new word.
// No dependencies.
module zpc_line_buf #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && waddr == raddr) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/zpc_mac.sv
// zpc_mac: weighted window sum: products, row sums, total, then round and clamp.
// Three register stages, all held by en. Depends on zpc_pkg.
module zpc_mac #(
	parameter int KERNEL_H = 5,
	parameter int KERNEL_W = 5
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              en,
	input  logic                                              in_valid,
	input  zpc_pkg::tag_t                                     in_tag,
	input  logic [KERNEL_H-1:0]                               row_ok,
	input  logic [KERNEL_W-1:0]                               col_ok,
	input  logic [KERNEL_H-1:0][KERNEL_W-1:0][zpc_pkg::PIX_W-1:0] win,
	input  logic [KERNEL_H*KERNEL_W-1:0][zpc_pkg::COEF_W-1:0] coef,
	output logic                                              out_valid,
	output zpc_pkg::result_t                                  out_res
);
	import zpc_pkg::*;

	localparam int TAPS = KERNEL_H * KERNEL_W;
	localparam int PW   = PIX_W + 1 + COEF_W;
	localparam int RW   = PW + $clog2(KERNEL_W);
	localparam int SW   = PW + $clog2(TAPS);
	localparam int TW   = SW + 1;

	logic [PIX_W-1:0]     pix_m   [KERNEL_H][KERNEL_W];
	logic signed [PW-1:0] prod_c  [KERNEL_H][KERNEL_W];
	logic signed [PW-1:0] prod_s1 [KERNEL_H][KERNEL_W];
	logic signed [RW-1:0] rsum_c  [KERNEL_H];
	logic signed [RW-1:0] rsum_s2 [KERNEL_H];
	logic signed [SW-1:0] total_c;
	logic signed [SW-1:0] sum_s3;
	logic signed [TW-1:0] rnd;
	logic                 valid_s1, valid_s2, valid_s3;
	tag_t                 tag_s1, tag_s2, tag_s3;

	// taps outside the image read as zero
	always_comb begin
		for (int r = 0; r < KERNEL_H; r++) begin
			for (int c = 0; c < KERNEL_W; c++) begin
				pix_m[r][c]  = (row_ok[r] && col_ok[c]) ? win[r][c] : '0;
				prod_c[r][c] = $signed({1'b0, pix_m[r][c]}) * $signed(coef[r*KERNEL_W + c]);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < KERNEL_H; r++) begin
			rsum_c[r] = '0;
			for (int c = 0; c < KERNEL_W; c++) begin
				rsum_c[r] = rsum_c[r] + RW'(prod_s1[r][c]);
			end
		end
	end

	always_comb begin
		total_c = '0;
		for (int r = 0; r < KERNEL_H; r++) begin
			total_c = total_c + SW'(rsum_s2[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
			rsum_s2 <= rsum_c;
			sum_s3  <= total_c;
			tag_s1  <= in_tag;
			tag_s2  <= tag_s1;
			tag_s3  <= tag_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// round half up, then clamp to the pixel range
	always_comb begin
		rnd                = TW'(sum_s3) + TW'(ROUND_HALF);
		out_res.out_row    = tag_s3.row;
		out_res.out_col    = tag_s3.col;
		out_res.frame_last = tag_s3.last;
		if (rnd[TW-1]) begin
			out_res.out_pixel = '0;
			out_res.clamped   = 1'b1;
		end else if (rnd[TW-2:FRAC_BITS+PIX_W] != '0) begin
			out_res.out_pixel = '1;
			out_res.clamped   = 1'b1;
		end else begin
			out_res.out_pixel = rnd[FRAC_BITS +: PIX_W];
			out_res.clamped   = 1'b0;
		end
	end

	assign out_valid = valid_s3;

endmodule

// File: hw/rtl/zpc_out_buf.sv
// zpc_out_buf: two-entry result buffer in front of the result channel.
// room drops only when both entries hold results. Depends on zpc_pkg, zpc_if.
module zpc_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  zpc_pkg::result_t din,
	output logic             room,
	zpc_result_if.source     results
);
	import zpc_pkg::*;

	localparam int DEPTH = 2;

	result_t    entry_q [DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop                = results.valid && results.ready;
	assign room               = count_q < 2'(DEPTH);
	assign results.valid      = count_q != '0;
	assign results.out_pixel  = entry_q[rd_ptr_q].out_pixel;
	assign results.out_row    = entry_q[rd_ptr_q].out_row;
	assign results.out_col    = entry_q[rd_ptr_q].out_col;
	assign results.clamped    = entry_q[rd_ptr_q].clamped;
	assign results.frame_last = entry_q[rd_ptr_q].frame_last;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> room)
		else $error("result pushed into a full buffer");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("result buffer count out of range");
`endif

endmodule

// File: hw/rtl/zero_padded_2d_convolution_unit.sv
// zero_padded_2d_convolution_unit: streaming same-size 2-D convolution, zero padded.
// Depends on zpc_pkg, zpc_if, zpc_line_buf, zpc_mac, zpc_out_buf.
//
// Usage:
//   items carries one request per accepted cycle: a coefficient load (tap index and
//   signed Q1.16 value), a pixel in raster order, or a drain step that counts as a
//   zero pixel. results carries one filtered pixel with its row, column, clamp flag
//   and end-of-frame flag. cfg_we/cfg_index/cfg_data set image width and height,
//   only while the unit is idle; each write restarts the frame.
// Throughput: one request per cycle, sustained while items.ready is high. The line
//   memory takes one read and one write per pixel, and the datapath is fully pipelined.
// Result order: the result for (row, col) is caused by the stream item KERNEL_H/2 rows
//   plus KERNEL_W/2 items later; it passes the request register, window, products,
//   row sums, total and result buffer registers before it shows on results.
// Reset: coefficient table cleared, width 640, height 480, counters zero. The line
//   memory is not cleared; taps outside the image are masked instead.
// Stall: a two-entry result buffer absorbs a stalled receiver; items.ready drops
//   only when both entries are full, and the whole pipeline holds while it is low.
module zero_padded_2d_convolution_unit #(
	parameter int KERNEL_H  = 5,
	parameter int KERNEL_W  = 5,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	zpc_item_if.sink                         items,
	zpc_result_if.source                     results,
	input  logic                             cfg_we,
	input  logic [zpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [zpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import zpc_pkg::*;

	localparam int KH_HALF    = KERNEL_H / 2;
	localparam int KW_HALF    = KERNEL_W / 2;
	localparam int TAPS       = KERNEL_H * KERNEL_W;
	localparam int NLB        = (KERNEL_H > 1) ? KERNEL_H - 1 : 1;
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int LAG_MAX    = KH_HALF * MAX_WIDTH + KW_HALF;
	localparam int LW         = $clog2(LAG_MAX + 2);
	localparam int WIDTH_INIT = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

	logic                en, acc, is_stream, acc_stream, produce, at_last;
	logic                col_wrap, ptr_wrap, cfg_hit;
	logic [WREG_W-1:0]   wv;
	logic [HREG_W-1:0]   hv;
	logic [WW-1:0]       width_q, width_sat;
	logic [HREG_W-1:0]   height_q, height_sat;
	logic [LW-1:0]       lag, cnt_q;
	logic [ROW_W-1:0]    orow_q;
	logic [CW-1:0]       ocol_q, lb_ptr_q;
	logic [KERNEL_H-1:0] row_ok, s1_row_ok, s2_row_ok;
	logic [KERNEL_W-1:0] col_ok, s1_col_ok, s2_col_ok;
	tag_t                cur_tag, s1_tag, s2_tag;

	logic                     s1_valid, s1_stream, s1_res;
	logic [FUNC_W-1:0]        s1_func;
	logic [PIX_W-1:0]         s1_pix;
	logic [IDX_W-1:0]         s1_idx;
	logic [COEF_W-1:0]        s1_coef;
	logic [CW-1:0]            s1_ptr;
	logic                     s2_valid;
	logic                     shift_en, coef_we;

	logic [NLB-1:0][PIX_W-1:0]                   lb_wdata, lb_rdata;
	logic [KERNEL_H-1:0][PIX_W-1:0]              col_in;
	logic [KERNEL_H-1:0][KERNEL_W-1:0][PIX_W-1:0] win_q;
	logic [TAPS-1:0][COEF_W-1:0]                 coef_q;

	logic    mac_valid;
	result_t mac_res;

	// ---------------- configuration ----------------
	always_comb begin
		wv = cfg_data[WREG_W-1:0];
		hv = cfg_data[HREG_W-1:0];
		if (wv == '0) begin
			width_sat = WW'(1);
		end else if (32'(wv) > MAX_WIDTH) begin
			width_sat = WW'(MAX_WIDTH);
		end else begin
			width_sat = WW'(wv);
		end
		if (hv == '0) begin
			height_sat = HREG_W'(1);
		end else if (32'(hv) > MAX_HEIGHT) begin
			height_sat = HREG_W'(MAX_HEIGHT);
		end else begin
			height_sat = hv;
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == REG_IMG_WIDTH || cfg_index == REG_IMG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(WIDTH_INIT);
			height_q <= HREG_W'(HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMG_WIDTH:  width_q  <= width_sat;
				REG_IMG_HEIGHT: height_q <= height_sat;
				default: ;
			endcase
		end
	end

	// ---------------- request side: position tracking ----------------
	assign en         = items.ready;
	assign acc        = items.valid && en;
	assign is_stream  = items.func == FUNC_PIXEL || items.func == FUNC_DRAIN;
	assign acc_stream = acc && is_stream;

	// items until the first output: KERNEL_H/2 rows plus KERNEL_W/2 items
	assign lag      = LW'(KH_HALF * 32'(width_q) + KW_HALF);
	assign produce  = cnt_q == lag;
	assign col_wrap = WW'(ocol_q) == width_q - 1'b1;
	assign ptr_wrap = WW'(lb_ptr_q) == width_q - 1'b1;
	assign at_last  = ({1'b0, orow_q} == height_q - 1'b1) && col_wrap;

	assign cur_tag.row  = orow_q;
	assign cur_tag.col  = COL_W'(ocol_q);
	assign cur_tag.last = at_last;

	always_comb begin
		for (int r = 0; r < KERNEL_H; r++) begin
			row_ok[r] = (int'(orow_q) + r - KH_HALF >= 0) &&
				(int'(orow_q) + r - KH_HALF < int'(height_q));
		end
		for (int c = 0; c < KERNEL_W; c++) begin
			col_ok[c] = (int'(ocol_q) + c - KW_HALF >= 0) &&
				(int'(ocol_q) + c - KW_HALF < int'(width_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			orow_q   <= '0;
			ocol_q   <= '0;
			lb_ptr_q <= '0;
		end else if (cfg_hit) begin
			cnt_q    <= '0;
			orow_q   <= '0;
			ocol_q   <= '0;
			lb_ptr_q <= '0;
		end else if (acc_stream) begin
			lb_ptr_q <= ptr_wrap ? '0 : lb_ptr_q + 1'b1;
			if (!produce) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (at_last) begin
				cnt_q  <= '0;
				orow_q <= '0;
				ocol_q <= '0;
			end else if (col_wrap) begin
				ocol_q <= '0;
				orow_q <= orow_q + 1'b1;
			end else begin
				ocol_q <= ocol_q + 1'b1;
			end
		end
	end

	// ---------------- request register ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			s1_func   <= items.func;
			s1_stream <= is_stream;
			s1_res    <= is_stream && produce;
			s1_pix    <= (items.func == FUNC_PIXEL) ? items.pixel : '0;
			s1_idx    <= items.coef_index;
			s1_coef   <= items.coef_value;
			s1_ptr    <= lb_ptr_q;
			s1_tag    <= cur_tag;
			s1_row_ok <= row_ok;
			s1_col_ok <= col_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2_tag    <= s1_tag;
			s2_row_ok <= s1_row_ok;
			s2_col_ok <= s1_col_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else if (en) begin
			s1_valid <= acc;
			s2_valid <= s1_valid && s1_res;
		end
	end

	// ---------------- line memory and window ----------------
	assign shift_en = en && s1_valid && s1_stream;

	// word k holds the item (k+1) lines back; writing shifts every line down one
	always_comb begin
		lb_wdata[0] = s1_pix;
		for (int k = 1; k < NLB; k++) begin
			lb_wdata[k] = lb_rdata[k-1];
		end
		for (int r = 0; r < KERNEL_H - 1; r++) begin
			col_in[r] = lb_rdata[KERNEL_H-2-r];
		end
		col_in[KERNEL_H-1] = s1_pix;
	end

	zpc_line_buf #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (NLB * PIX_W)
	) u_line_buf (
		.clk   (clk),
		.we    (shift_en),
		.waddr (s1_ptr),
		.wdata (lb_wdata),
		.re    (acc),
		.raddr (lb_ptr_q),
		.rdata (lb_rdata)
	);

	// column KERNEL_W-1 holds the newest item of each row
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int r = 0; r < KERNEL_H; r++) begin
				for (int c = 0; c < KERNEL_W - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][KERNEL_W-1] <= col_in[r];
			end
		end
	end

	// taps change at the window stage so earlier pixels keep the old kernel
	assign coef_we = en && s1_valid && s1_func == FUNC_LOAD && 32'(s1_idx) < TAPS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (coef_we) begin
			for (int t = 0; t < TAPS; t++) begin
				if (32'(s1_idx) == t) begin
					coef_q[t] <= s1_coef;
				end
			end
		end
	end

	// ---------------- datapath and result buffer ----------------
	zpc_mac #(
		.KERNEL_H (KERNEL_H),
		.KERNEL_W (KERNEL_W)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s2_valid),
		.in_tag    (s2_tag),
		.row_ok    (s2_row_ok),
		.col_ok    (s2_col_ok),
		.win       (win_q),
		.coef      (coef_q),
		.out_valid (mac_valid),
		.out_res   (mac_res)
	);

	zpc_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (en && mac_valid),
		.din     (mac_res),
		.room    (items.ready),
		.results (results)
	);

`ifndef SYNTHESIS
	a_col_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(ocol_q) < width_q)
		else $error("output column beyond image width");
	a_row_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, orow_q} < height_q)
		else $error("output row beyond image height");
	a_warmup_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= lag)
		else $error("warm-up count passed the lag");
`endif

endmodule

// File: verif/tb_zero_padded_2d_convolution_unit.sv
// tb_zero_padded_2d_convolution_unit: self-checking bench for the zero-padded 2-D convolution unit.
// Directed and random request streams, a local convolution predictor and field-by-field checks.
// Depends on zpc_pkg, zpc_if and the RTL of zero_padded_2d_convolution_unit.
module tb_zero_padded_2d_convolution_unit;
	import zpc_pkg::*;

	localparam int KH = 5;
	localparam int KW = 5;
	localparam int MAXW = 1024;
	localparam int TAPS = KH * KW;
	localparam int HIST_D = 8192;
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int DRAIN_CYCLES = 16;
	localparam int TOTAL_ITEMS = 1350;
	localparam int unsigned LIMIT = 2_000_000;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [PIX_W-1:0]         pixel;
		logic [IDX_W-1:0]         coef_index;
		logic signed [COEF_W-1:0] coef_value;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	zpc_item_if items ();
	zpc_result_if results ();

	zero_padded_2d_convolution_unit #(
		.KERNEL_H(KH),
		.KERNEL_W(KW),
		.MAX_WIDTH(MAXW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic signed [COEF_W-1:0] taps [TAPS];
	logic [PIX_W-1:0] hist [HIST_D];
	int unsigned in_cnt = 0;
	int unsigned cur_w = WIDTH_RST;
	int unsigned cur_h = HEIGHT_RST;

	req_t pending_req [$];
	result_t expected_pix [$];

	int errors = 0;
	int fed = 0;
	int gap_mode = 1;
	int stall_mode = 1;
	int coef_style = 0;
	int gap_left = 0;
	int stall_left = 0;
	int unsigned cycles = 0;
	req_t seen;
	req_t nxt;
	result_t want;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("zero_padded_2d_convolution_unit: mismatch");
			$finish;
		end
	end

	function automatic int pick_delay(input int mode);
		int r;
		if (mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(6, 16);
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		int v;
		case (coef_style)
			0: v = int'($urandom_range(0, 262143)) - 131072;
			1: v = $urandom_range(0, 6000);
			default: v = int'($urandom_range(0, 8000)) - 4000;
		endcase
		return v[COEF_W-1:0];
	endfunction

	// unused fields carry random bits
	function automatic req_t rand_req(input logic [FUNC_W-1:0] f);
		req_t r;
		r = '0;
		r.func = f;
		r.pixel = 8'($urandom);
		r.coef_index = 5'($urandom);
		r.coef_value = 18'($urandom);
		return r;
	endfunction

	task automatic convolve_request(input req_t r);
		int unsigned p, q, lag, total, row, col, pos;
		int i, j, rr, cc;
		longint acc, t;
		result_t res;
		if (r.func == FUNC_LOAD) begin
			if (r.coef_index < TAPS)
				taps[r.coef_index] = r.coef_value;
		end else if (r.func == FUNC_PIXEL || r.func == FUNC_DRAIN) begin
			p = in_cnt;
			hist[p % HIST_D] = (r.func == FUNC_PIXEL) ? r.pixel : '0;
			in_cnt = p + 1;
			lag = (KH / 2) * cur_w + KW / 2;
			total = cur_w * cur_h;
			if (p >= lag) begin
				q = p - lag;
				if (q >= total) begin
					in_cnt = 0;
				end else begin
					row = q / cur_w;
					col = q % cur_w;
					acc = 0;
					for (i = 0; i < KH; i++) begin
						for (j = 0; j < KW; j++) begin
							rr = int'(row) + i - KH / 2;
							cc = int'(col) + j - KW / 2;
							if (rr >= 0 && rr < int'(cur_h) && cc >= 0 && cc < int'(cur_w)) begin
								pos = rr * cur_w + cc;
								acc += longint'(hist[pos % HIST_D]) * longint'(taps[i * KW + j]);
							end
						end
					end
					// round half up, then clamp to the pixel range
					t = acc + ROUND_HALF;
					res.clamped = 1'b0;
					if (t < 0) begin
						res.out_pixel = '0;
						res.clamped = 1'b1;
					end else if ((t >>> FRAC_BITS) > 255) begin
						res.out_pixel = '1;
						res.clamped = 1'b1;
					end else begin
						res.out_pixel = t[FRAC_BITS +: PIX_W];
					end
					res.out_row = row[ROW_W-1:0];
					res.out_col = col[COL_W-1:0];
					res.frame_last = (q == total - 1);
					if (res.frame_last)
						in_cnt = 0;
					expected_pix.push_back(res);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (items.valid && items.ready) begin
				seen.func = items.func;
				seen.pixel = items.pixel;
				seen.coef_index = items.coef_index;
				seen.coef_value = items.coef_value;
				convolve_request(seen);
			end
			if (!items.valid || items.ready) begin
				if (gap_left == 0 && pending_req.size() != 0) begin
					nxt = pending_req.pop_front();
					items.valid <= 1'b1;
					items.func <= nxt.func;
					items.pixel <= nxt.pixel;
					items.coef_index <= nxt.coef_index;
					items.coef_value <= nxt.coef_value;
					gap_left = pick_delay(gap_mode);
				end else begin
					items.valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (results.valid && results.ready) begin
				if (expected_pix.size() == 0) begin
					errors++;
					$display("%0t: expected no result, actual pixel %0d row %0d col %0d",
						$time, results.out_pixel, results.out_row, results.out_col);
				end else begin
					want = expected_pix.pop_front();
					check_field("out_pixel", want.out_pixel, results.out_pixel);
					check_field("out_row", want.out_row, results.out_row);
					check_field("out_col", want.out_col, results.out_col);
					check_field("clamped", want.clamped, results.clamped);
					check_field("frame_last", want.frame_last, results.frame_last);
				end
			end
			if (stall_left != 0) begin
				results.ready <= 1'b0;
				stall_left--;
			end else begin
				results.ready <= 1'b1;
				stall_left = pick_delay(stall_mode);
			end
		end
	end

	task automatic wait_idle(input int pad);
		do
			@(negedge clk);
		while (pending_req.size() != 0 || items.valid || expected_pix.size() != 0);
		repeat (pad) @(posedge clk);
	endtask

	// register write; the mirror saturates like the block and restarts the frame
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		int unsigned v;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMG_WIDTH) begin
			v = data[WREG_W-1:0];
			cur_w = (v == 0) ? 1 : (v > MAXW) ? MAXW : v;
		end else if (idx == REG_IMG_HEIGHT) begin
			v = data[HREG_W-1:0];
			cur_h = (v == 0) ? 1 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
		end
		in_cnt = 0;
		@(negedge clk);
	endtask

	task automatic push_load(input int idx, input logic signed [COEF_W-1:0] val);
		req_t r;
		r = rand_req(FUNC_LOAD);
		r.coef_index = idx[IDX_W-1:0];
		r.coef_value = val;
		pending_req.push_back(r);
		if (idx < TAPS)
			fed++;
	endtask

	task automatic push_stream(input logic [FUNC_W-1:0] f, input int pix);
		req_t r;
		r = rand_req(f);
		r.pixel = pix[PIX_W-1:0];
		pending_req.push_back(r);
		fed++;
	endtask

	task automatic load_kernel();
		int k;
		for (k = 0; k < TAPS; k++)
			if ($urandom_range(0, 3) != 0)
				push_load(k, rand_coef());
		if ($urandom_range(0, 1))
			push_load(TAPS / 2, 18'sh10000);
	endtask

	// one frame: image pixels, then padding items that count as zero until the last result is due.
	// cut stops it at a random point, pause holds the sender once until all results are back
	task automatic queue_frame(input bit cut, input bit pause);
		int n, k, pause_at, img;
		img = cur_w * cur_h;
		n = (KH / 2) * cur_w + KW / 2 + img;
		pause_at = pause ? $urandom_range(0, n - 1) : -1;
		if (cut)
			n = $urandom_range(0, n - 1);
		for (k = 0; k < n; k++) begin
			if (k == pause_at)
				wait_idle(0);
			if ($urandom_range(0, 99) < 4)
				push_load(($urandom_range(0, 3) != 0) ? $urandom_range(0, TAPS - 1) :
					$urandom_range(0, 31), rand_coef());
			if ($urandom_range(0, 99) < 2)
				pending_req.push_back(rand_req(FUNC_NONE));
			if (k < img)
				push_stream(($urandom_range(0, 99) < 3) ? FUNC_DRAIN : FUNC_PIXEL,
					$urandom_range(0, 255));
			else
				push_stream($urandom_range(0, 1) ? FUNC_DRAIN : FUNC_PIXEL,
					$urandom_range(0, 255));
		end
	endtask

	initial begin
		int k, w, h, sel, frames, f;
		items.valid = 1'b0;
		items.func = FUNC_NONE;
		items.pixel = '0;
		items.coef_index = '0;
		items.coef_value = '0;
		results.ready = 1'b0;
		for (k = 0; k < TAPS; k++)
			taps[k] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 3x2 image, tap and pixel extremes, ignored requests
		write_reg(REG_IMG_WIDTH, 3);
		write_reg(REG_IMG_HEIGHT, 2);
		push_load(12, 18'sh10000);
		push_load(6, 18'sh20000);
		push_load(18, 18'sh1FFFF);
		push_load(0, 100);
		push_load(24, -100);
		push_load(25, 77);
		push_load(31, -1);
		pending_req.push_back(rand_req(FUNC_NONE));
		push_stream(FUNC_PIXEL, 255);
		push_stream(FUNC_PIXEL, 0);
		push_stream(FUNC_PIXEL, 255);
		push_stream(FUNC_DRAIN, 0);
		push_stream(FUNC_PIXEL, 128);
		push_stream(FUNC_PIXEL, 1);
		// past the image end a pixel counts as zero
		push_stream(FUNC_PIXEL, 200);
		push_stream(FUNC_DRAIN, 0);
		push_stream(FUNC_PIXEL, 255);
		repeat (5) push_stream(FUNC_DRAIN, 0);
		wait_idle(DRAIN_CYCLES);

		// zero writes saturate up to a 1x1 image
		write_reg(REG_IMG_WIDTH, 0);
		write_reg(REG_IMG_HEIGHT, 0);
		queue_frame(1'b0, 1'b0);
		queue_frame(1'b0, 1'b0);
		wait_idle(DRAIN_CYCLES);

		// wide line, the line memory wraps many times, sender held once mid-frame
		coef_style = 2;
		write_reg(REG_IMG_WIDTH, 60);
		write_reg(REG_IMG_HEIGHT, 3);
		load_kernel();
		queue_frame(1'b0, 1'b1);
		wait_idle(DRAIN_CYCLES);

		// tall image, one column
		coef_style = 1;
		write_reg(REG_IMG_WIDTH, 1);
		write_reg(REG_IMG_HEIGHT, 120);
		load_kernel();
		queue_frame(1'b0, 1'b0);
		wait_idle(DRAIN_CYCLES);

		while (fed < TOTAL_ITEMS) begin
			gap_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
			stall_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
			coef_style = $urandom_range(0, 2);
			if ($urandom_range(0, 9) < 6)
				w = $urandom_range(1, 8);
			else if ($urandom_range(0, 3) != 0)
				w = $urandom_range(9, 20);
			else
				w = $urandom_range(21, 40);
			h = (w > 20) ? $urandom_range(1, 3) : $urandom_range(1, 7);
			sel = $urandom_range(0, 4);
			// a single-register write keeps the other size, so only when that one is small
			if (sel == 0 && cur_h <= 7) begin
				write_reg(REG_IMG_WIDTH, w | ($urandom_range(0, 3) << WREG_W));
			end else if (sel == 1 && cur_w <= 20) begin
				write_reg(REG_IMG_HEIGHT, h);
			end else begin
				write_reg(REG_IMG_WIDTH, w | ($urandom_range(0, 3) << WREG_W));
				write_reg(REG_IMG_HEIGHT, h);
			end
			if ($urandom_range(0, 1))
				load_kernel();
			frames = $urandom_range(1, 2);
			for (f = 0; f < frames; f++)
				queue_frame(f == frames - 1 && $urandom_range(0, 3) == 0,
					$urandom_range(0, 4) == 0);
			wait_idle(DRAIN_CYCLES);
		end

		if (errors == 0)
			$display("zero_padded_2d_convolution_unit: match");
		else
			$display("zero_padded_2d_convolution_unit: mismatch");
		$finish;
	end

endmodule
